@@ rtl/oktsl_pkg.sv @@
// ---------------------------------------------------------------------------
// oktsl_pkg: shared types and constants for the ordered key table
// Controller states, operation codes, status codes, register indexes and
// the command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package oktsl_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;
   localparam logic [1:0] OP_NEXT   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [1:0] REG_FROZEN     = 2'd0;
   localparam logic [1:0] REG_ENTRY_LIM  = 2'd1;
   localparam logic [1:0] REG_BYTE_LIM   = 2'd2;
   localparam logic [1:0] REG_NAME_LIM   = 2'd3;

   localparam logic [31:0] RNG_SEED  = 32'h9E37_79B9;
   localparam logic [26:0] BYTES_MAX = 27'h7FF_FFFF;
   localparam logic [6:0]  HDR_BYTES = 7'd78;

   typedef enum logic [3:0] {
      S_IDLE,      // wait for an item
      S_CHECK,     // classify the op
      S_LVL_RD,    // issue read of current node link at level
      S_LVL_WT,    // link data back
      S_KEY_RD,    // issue read of candidate key
      S_KEY_WT,    // compare candidate key
      S_FOUND_RD,  // read level-0 successor payload
      S_FOUND_WT,
      S_HEIGHT,    // draw tower height
      S_LINK_RD,   // read pred link at level i
      S_LINK_WT,
      S_LINK_WR,   // write pred link at level i (new node link is written in S_LINK_WT)
      S_ITER_WT,   // iterator payload read, or insert commit
      S_RESP       // raise result valid; it holds until taken
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       walk_init;   // x = head, lvl = top - 1
      logic       rd_link;     // read link(x, lvl)
      logic       rd_node;     // read payload of link data
      logic       advance;     // x = nx
      logic       save_pred;   // preds[lvl] = x, lvl--
      logic       found_sel;   // nx becomes candidate for match check
      logic       height_step; // one rng step while growing
      logic       height_done;
      logic       link_rd;     // read link(preds[i], i)
      logic       link_wr_new; // write new node link
      logic       link_wr_pred;// write pred link, i++
      logic       commit_new;
      logic       commit_over;
      logic       iter_start;
      logic       iter_rd;
      logic       iter_take;
      logic [1:0] status;
      logic       hit;
      logic       resp_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       refused;
      logic       full;
      logic       nx_null;
      logic       key_less;
      logic       key_equal;
      logic       lvl_zero;
      logic       grow;        // height draw continues
      logic       link_done;   // all tower levels linked
      logic       cursor_null;
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/oktsl_ram.sv @@
// ---------------------------------------------------------------------------
// oktsl_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module oktsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

@@ rtl/oktsl_datapath.sv @@
// ---------------------------------------------------------------------------
// oktsl_datapath: node memories, walk registers and accounting
// Holds the skip list storage, the search pointer, predecessor list,
// height generator, counters and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module oktsl_datapath #(
   parameter int CAPACITY   = 1024,
   parameter int MAX_LEVELS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire oktsl_pkg::ctl_cmd_type cmd,
   output oktsl_pkg::dp_status_type    sts,
   input  wire logic [1:0]             op,
   input  wire logic [63:0]            key,
   input  wire logic [31:0]            entry_handle,
   input  wire logic [15:0]            name_length,
   input  wire logic                   frozen,
   input  wire logic [10:0]            flush_entry_limit,
   input  wire logic [26:0]            flush_byte_limit,
   input  wire logic [15:0]            name_length_limit,
   output logic [1:0]                  status_out,
   output logic                        hit_out,
   output logic [63:0]                 key_out,
   output logic [31:0]                 handle_out,
   output logic [15:0]                 length_out,
   output logic [10:0]                 entry_count,
   output logic [26:0]                 byte_total,
   output logic [63:0]                 largest_key,
   output logic                        flush_needed
);
   localparam int AW = $clog2(CAPACITY);
   localparam int PW = AW + 1;          // pointer: node, null=CAPACITY
   localparam int LW = $clog2(MAX_LEVELS);
   localparam int TW = $clog2(MAX_LEVELS + 1);
   localparam logic [PW-1:0] PNULL = PW'(CAPACITY);
   localparam logic [6:0]  HDR_BYTES_W = oktsl_pkg::HDR_BYTES;
   localparam logic [26:0] BYTES_MAX_W = oktsl_pkg::BYTES_MAX;

   // item registers
   logic [1:0]  op_ff;
   logic [63:0] key_ff;
   logic [31:0] hnd_ff;
   logic [15:0] len_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= op;
         key_ff <= key;
         hnd_ff <= entry_handle;
         len_ff <= name_length;
      end
   end

   // walk state
   logic [PW-1:0] x_ff, nx_ff, cur_ff;
   logic          xhead_ff;
   logic [LW-1:0] lvl_ff;
   logic [TW-1:0] top_ff, hgt_ff;
   logic [LW-1:0] li_ff;
   logic [PW-1:0] preds_ff [MAX_LEVELS];
   logic          phead_ff [MAX_LEVELS];
   logic [PW-1:0] head_ff [MAX_LEVELS];
   logic [31:0]   rng_ff;
   logic [10:0]   cnt_ff;
   logic [26:0]   bytes_ff;
   logic [63:0]   max_ff;
   logic [PW-1:0] cand_ff;

   // memories
   logic                 kwe, lwe;
   logic [AW-1:0]        kaddr;
   logic [63:0]          krd;
   logic [31:0]          hrd;
   logic [15:0]          lrd;
   logic [AW+LW-1:0]     laddr;
   logic [PW-1:0]        lwd, lrd_link;

   oktsl_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_keys (
      .clock(clock), .we(kwe && cmd.commit_new), .addr(kaddr),
      .wdata(key_ff), .rdata(krd));
   oktsl_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_hnd (
      .clock(clock), .we(kwe), .addr(kaddr), .wdata(hnd_ff), .rdata(hrd));
   oktsl_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_len (
      .clock(clock), .we(kwe), .addr(kaddr), .wdata(len_ff), .rdata(lrd));
   oktsl_ram #(.WIDTH(PW), .DEPTH(CAPACITY * MAX_LEVELS)) u_links (
      .clock(clock), .we(lwe), .addr(laddr), .wdata(lwd), .rdata(lrd_link));

   // link read: head links from flops, node links from memory
   logic          lsrc_head_ff;
   logic [PW-1:0] lhead_ff;
   logic [PW-1:0] link_val;
   assign link_val = lsrc_head_ff ? lhead_ff : lrd_link;

   logic [PW-1:0] new_node;
   assign new_node = PW'(cnt_ff);

   // address and write mux
   always_comb begin
      kwe   = cmd.commit_new || cmd.commit_over;
      kaddr = cmd.commit_new ? new_node[AW-1:0] : cand_ff[AW-1:0];
      if (cmd.rd_node) begin
         kaddr = link_val[AW-1:0];
      end else if (cmd.iter_rd) begin
         kaddr = cur_ff[AW-1:0];
      end
      lwe   = 1'b0;
      lwd   = PNULL;
      laddr = {x_ff[AW-1:0], lvl_ff};
      if (cmd.iter_rd) begin
         laddr = {cur_ff[AW-1:0], {LW{1'b0}}};
      end
      if (cmd.link_rd) begin
         laddr = {preds_ff[li_ff][AW-1:0], li_ff};
      end
      // new node takes the pred's old successor straight off the read data
      if (cmd.link_wr_new) begin
         lwe   = 1'b1;
         laddr = {new_node[AW-1:0], li_ff};
         lwd   = link_val;
      end
      if (cmd.link_wr_pred && !phead_ff[li_ff]) begin
         lwe   = 1'b1;
         laddr = {preds_ff[li_ff][AW-1:0], li_ff};
         lwd   = new_node;
      end
   end

   // byte accounting
   logic [27:0] b_add, b_over;
   logic [17:0] old_enc;
   assign b_add   = 28'(bytes_ff) + 28'(HDR_BYTES_W) + 28'(len_ff);
   assign old_enc = 18'(HDR_BYTES_W) + 18'(lrd);
   assign b_over  = (b_add >= 28'(old_enc)) ? b_add - 28'(old_enc) : 28'd0;

   logic [31:0] rng_nx;
   always_comb begin
      rng_nx = rng_ff ^ (rng_ff << 13);
      rng_nx = rng_nx ^ (rng_nx >> 17);
      rng_nx = rng_nx ^ (rng_nx << 5);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= TW'(1);
         rng_ff    <= oktsl_pkg::RNG_SEED;
         cnt_ff    <= '0;
         bytes_ff  <= '0;
         max_ff    <= '0;
         cur_ff    <= PNULL;
         lsrc_head_ff <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            head_ff[i] <= PNULL;
         end
      end else begin
         // walk start
         if (cmd.walk_init) begin
            xhead_ff <= 1'b1;
            lvl_ff   <= LW'(top_ff - TW'(1));
         end
         if (cmd.rd_link) begin
            lsrc_head_ff <= xhead_ff;
            lhead_ff     <= head_ff[lvl_ff];
         end
         if (cmd.rd_node) begin
            nx_ff <= link_val;
         end
         if (cmd.advance) begin
            x_ff     <= nx_ff;
            xhead_ff <= 1'b0;
         end
         if (cmd.save_pred) begin
            preds_ff[lvl_ff] <= x_ff;
            phead_ff[lvl_ff] <= xhead_ff;
            if (lvl_ff != '0) begin
               lvl_ff <= lvl_ff - LW'(1);
            end
         end
         if (cmd.found_sel) begin
            cand_ff <= nx_ff;
         end
         // height draw
         if (cmd.height_step) begin
            rng_ff <= rng_nx;
            hgt_ff <= hgt_ff + TW'(1);
         end
         if (cmd.walk_init) begin
            hgt_ff <= TW'(1);
         end
         if (cmd.height_done) begin
            rng_ff <= rng_nx;
            li_ff  <= '0;
            if (hgt_ff > top_ff) begin
               for (int i = 0; i < MAX_LEVELS; i++) begin
                  if (TW'(i) >= top_ff && TW'(i) < hgt_ff) begin
                     phead_ff[i] <= 1'b1;
                  end
               end
               top_ff <= hgt_ff;
            end
         end
         // link splice: read successor of pred, then write both
         if (cmd.link_rd) begin
            lsrc_head_ff <= phead_ff[li_ff];
            lhead_ff     <= head_ff[li_ff];
         end
         if (cmd.link_wr_pred) begin
            if (phead_ff[li_ff]) begin
               head_ff[li_ff] <= new_node;
            end
            li_ff <= li_ff + LW'(1);
         end
         // commits
         if (cmd.commit_new) begin
            cnt_ff   <= cnt_ff + 11'd1;
            bytes_ff <= b_add[27] ? BYTES_MAX_W : b_add[26:0];
            if (key_ff > max_ff) max_ff <= key_ff;
         end
         if (cmd.commit_over) begin
            bytes_ff <= (b_over > 28'(BYTES_MAX_W)) ? BYTES_MAX_W : b_over[26:0];
            if (key_ff > max_ff) max_ff <= key_ff;
         end
         // iterator
         if (cmd.iter_start) begin
            cur_ff <= head_ff[0];
         end
         if (cmd.iter_take) begin
            cur_ff <= lrd_link;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         status_out <= cmd.status;
         hit_out    <= cmd.hit;
         key_out    <= cmd.hit ? krd : 64'd0;
         handle_out <= cmd.hit ? hrd : 32'd0;
         length_out <= cmd.hit ? lrd : 16'd0;
      end
   end
   assign entry_count  = cnt_ff;
   assign byte_total   = bytes_ff;
   assign largest_key  = max_ff;
   assign flush_needed = (cnt_ff >= flush_entry_limit) || (bytes_ff >= flush_byte_limit);

   // status to controller
   always_comb begin
      sts.op          = op_ff;
      sts.refused     = frozen || (len_ff > name_length_limit);
      sts.full        = (cnt_ff >= 11'(CAPACITY));
      sts.nx_null     = (link_val >= PNULL);
      sts.key_less    = (krd < key_ff);
      sts.key_equal   = (krd == key_ff) && (cand_ff < PNULL);
      sts.lvl_zero    = (lvl_ff == '0);
      sts.grow        = (hgt_ff < TW'(MAX_LEVELS)) && (rng_ff[1:0] == 2'b00);
      sts.link_done   = (TW'(li_ff) + TW'(1) >= hgt_ff);
      sts.cursor_null = (cur_ff >= PNULL);
   end
endmodule
`default_nettype wire

@@ rtl/oktsl_ctrl.sv @@
// ---------------------------------------------------------------------------
// oktsl_ctrl: sequencer for the ordered key table
// Walks the skip list one memory read at a time and drives the datapath.
// ---------------------------------------------------------------------------
`default_nettype none
module oktsl_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output oktsl_pkg::ctl_cmd_type         cmd,
   input  wire oktsl_pkg::dp_status_type  sts,
   output oktsl_pkg::ctl_state_type       state
);
   oktsl_pkg::ctl_state_type state_ff, state_in;
   logic valid_ff, valid_in;
   logic nx_null_q;
   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oktsl_pkg::S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !out_ready;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         oktsl_pkg::S_IDLE: begin
            // a waiting result holds off the next item
            in_ready = !valid_ff;
            if (in_valid && !valid_ff) begin
               cmd.load_item = 1'b1;
               state_in = oktsl_pkg::S_CHECK;
            end
         end
         oktsl_pkg::S_CHECK: begin
            cmd.walk_init = 1'b1;
            case (sts.op)
               oktsl_pkg::OP_INSERT: begin
                  if (sts.refused) begin
                     cmd.status = oktsl_pkg::ST_INVALID;
                     state_in = oktsl_pkg::S_RESP;
                  end else begin
                     state_in = oktsl_pkg::S_LVL_RD;
                  end
               end
               oktsl_pkg::OP_FIND:  state_in = oktsl_pkg::S_LVL_RD;
               oktsl_pkg::OP_START: begin
                  cmd.iter_start = 1'b1;
                  state_in = oktsl_pkg::S_RESP;
               end
               default: begin
                  if (sts.cursor_null) begin
                     state_in = oktsl_pkg::S_RESP;
                  end else begin
                     cmd.iter_rd = 1'b1;
                     state_in = oktsl_pkg::S_ITER_WT;
                  end
               end
            endcase
            if (state_in == oktsl_pkg::S_RESP) begin
               cmd.resp_load = 1'b1;
            end
         end
         oktsl_pkg::S_LVL_RD: begin
            cmd.rd_link = 1'b1;
            state_in = oktsl_pkg::S_LVL_WT;
         end
         oktsl_pkg::S_LVL_WT: begin
            cmd.rd_node = 1'b1;
            state_in = oktsl_pkg::S_KEY_WT;
         end
         oktsl_pkg::S_KEY_WT: begin
            // nx_ff valid, key data valid
            if (!nx_null_q && sts.key_less) begin
               cmd.advance = 1'b1;
               state_in = oktsl_pkg::S_LVL_RD;
            end else begin
               cmd.save_pred = 1'b1;
               cmd.found_sel = 1'b1;
               state_in = sts.lvl_zero ? oktsl_pkg::S_FOUND_RD : oktsl_pkg::S_LVL_RD;
            end
         end
         oktsl_pkg::S_FOUND_RD: begin
            // candidate address goes to the key read port here
            state_in = oktsl_pkg::S_FOUND_WT;
         end
         oktsl_pkg::S_FOUND_WT: begin
            if (sts.op == oktsl_pkg::OP_FIND) begin
               cmd.hit = sts.key_equal;
               cmd.resp_load = 1'b1;
               state_in = oktsl_pkg::S_RESP;
            end else if (sts.key_equal) begin
               cmd.commit_over = 1'b1;
               cmd.resp_load = 1'b1;
               state_in = oktsl_pkg::S_RESP;
            end else if (sts.full) begin
               cmd.status = oktsl_pkg::ST_FULL;
               cmd.resp_load = 1'b1;
               state_in = oktsl_pkg::S_RESP;
            end else begin
               state_in = oktsl_pkg::S_HEIGHT;
            end
         end
         oktsl_pkg::S_HEIGHT: begin
            if (sts.grow) begin
               cmd.height_step = 1'b1;
            end else begin
               cmd.height_done = 1'b1;
               state_in = oktsl_pkg::S_LINK_RD;
            end
         end
         oktsl_pkg::S_LINK_RD: begin
            cmd.link_rd = 1'b1;
            state_in = oktsl_pkg::S_LINK_WT;
         end
         oktsl_pkg::S_LINK_WT: begin
            cmd.link_wr_new = 1'b1;
            state_in = oktsl_pkg::S_LINK_WR;
         end
         oktsl_pkg::S_LINK_WR: begin
            cmd.link_wr_pred = 1'b1;
            if (sts.link_done) begin
               state_in = oktsl_pkg::S_ITER_WT;
            end else begin
               state_in = oktsl_pkg::S_LINK_RD;
            end
         end
         oktsl_pkg::S_ITER_WT: begin
            if (sts.op == oktsl_pkg::OP_NEXT) begin
               cmd.iter_take = 1'b1;
               cmd.hit = 1'b1;
            end else begin
               cmd.commit_new = 1'b1;
            end
            cmd.resp_load = 1'b1;
            state_in = oktsl_pkg::S_RESP;
         end
         oktsl_pkg::S_RESP: begin
            valid_in = 1'b1;
            state_in = oktsl_pkg::S_IDLE;
         end
         default: state_in = oktsl_pkg::S_IDLE;
      endcase
   end

   // null flag of the successor captured with the key read
   always_ff @(posedge clock) begin
      if (state_ff == oktsl_pkg::S_LVL_WT) begin
         nx_null_q <= sts.nx_null;
      end
   end
endmodule
`default_nettype wire

@@ rtl/ordered_key_table_skiplist_top.sv @@
// ---------------------------------------------------------------------------
// ordered_key_table_skiplist_top: sorted 64-bit key table on a skip list
// Insert/overwrite, exact find and an ascending iterator over node memories.
// ---------------------------------------------------------------------------
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | op, key, entry_handle, name_length
// rsp     | out | rsp_tvalid/tready    | status..flush_needed
// csr     | in  | csr_valid/csr_ready  | index, data
//
// One item at a time. Each hop of the level walk reads a link, then reads
// the candidate key and compares; an insert then links each tower level
// in turn (read pred link, write new node link, write pred link). The link
// memory is single-port. Reset is synchronous and clears the table; node
// memories need no clearing. A waiting result stalls the next item.
// ---------------------------------------------------------------------------
`default_nettype none
module ordered_key_table_skiplist_top #(
   parameter int CAPACITY   = 1024,
   parameter int MAX_LEVELS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [119:0] req_tdata,  // op[1:0] key[65:2] handle[97:66] len[113:98]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [223:0]      rsp_tdata,  // status, hit, key_out, handle_out, length_out,
                                         // entry_count, byte_total, largest_key, flush
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [26:0]  csr_data
);
   logic        frozen_ff;
   logic [10:0] ent_lim_ff;
   logic [26:0] byte_lim_ff;
   logic [15:0] name_lim_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff   <= 1'b0;
         ent_lim_ff  <= 11'd1024;
         byte_lim_ff <= 27'd1048576;
         name_lim_ff <= 16'd255;
      end else if (csr_valid) begin
         case (csr_index)
            oktsl_pkg::REG_FROZEN:    frozen_ff   <= csr_data[0];
            oktsl_pkg::REG_ENTRY_LIM: ent_lim_ff  <= csr_data[10:0];
            oktsl_pkg::REG_BYTE_LIM:  byte_lim_ff <= csr_data;
            oktsl_pkg::REG_NAME_LIM:  name_lim_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   oktsl_pkg::ctl_cmd_type    cmd;
   oktsl_pkg::dp_status_type  sts;
   oktsl_pkg::ctl_state_type  state;

   oktsl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd(cmd), .sts(sts), .state(state));

   logic [1:0]  st_o;
   logic        hit_o, fl_o;
   logic [63:0] k_o, mk_o;
   logic [31:0] h_o;
   logic [15:0] l_o;
   logic [10:0] c_o;
   logic [26:0] b_o;

   oktsl_datapath #(.CAPACITY(CAPACITY), .MAX_LEVELS(MAX_LEVELS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .op(req_tdata[1:0]), .key(req_tdata[65:2]),
      .entry_handle(req_tdata[97:66]), .name_length(req_tdata[113:98]),
      .frozen(frozen_ff), .flush_entry_limit(ent_lim_ff),
      .flush_byte_limit(byte_lim_ff), .name_length_limit(name_lim_ff),
      .status_out(st_o), .hit_out(hit_o), .key_out(k_o), .handle_out(h_o),
      .length_out(l_o), .entry_count(c_o), .byte_total(b_o),
      .largest_key(mk_o), .flush_needed(fl_o));

   assign rsp_tdata = {6'd0, fl_o, mk_o, b_o, c_o, l_o, h_o, k_o, hit_o, st_o};

   // an accepted item never arrives while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");
   // a miss reports a zero key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[2]) |-> (rsp_tdata[66:3] == 64'd0))
      else $error("miss with payload");
   // ready only in idle
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state == oktsl_pkg::S_IDLE)) else $error("ready outside idle");
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking bench for the ordered key table
// Streams insert, find and iterator items into the table, predicts every
// result with a sorted-map model kept in the bench and compares each field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int CAP = 1024;
   localparam int WDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [31:0] handle;
      logic [15:0] len;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [63:0] key_out;
      logic [31:0] handle_out;
      logic [15:0] length_out;
      logic [10:0] entry_count;
      logic [26:0] byte_total;
      logic [63:0] largest_key;
      logic        flush;
   } result_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [119:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [223:0]  rsp_tdata;
   logic          csr_valid = 0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [26:0]   csr_data = '0;

   ordered_key_table_skiplist_top dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // ---------------- predictor: sorted map in associative arrays ------------
   logic [31:0]  map_handle [logic [63:0]];
   logic [15:0]  map_len [logic [63:0]];
   logic         cfg_frozen = 0;
   logic [10:0]  cfg_entry_lim = 11'd1024;
   logic [26:0]  cfg_byte_lim = 27'd1048576;
   logic [15:0]  cfg_name_lim = 16'd255;
   logic [63:0]  key_max = 0;
   logic [27:0]  bytes_sum = 0;
   logic         cur_valid = 0;
   logic [63:0]  cur_key;

   result_type expected_q[$];
   item_type   pending_q[$];
   int         errors = 0;

   function automatic result_type predict_table(item_type c);
      result_type r;
      logic [63:0] k;
      logic signed [29:0] b;
      r = '0;
      case (c.op)
         oktsl_pkg::OP_INSERT: begin
            if (cfg_frozen || c.len > cfg_name_lim) r.status = oktsl_pkg::ST_INVALID;
            else if (map_handle.exists(c.key)) begin
               // header bytes cancel; clamp at zero and at the ceiling
               b = $signed({2'b00, bytes_sum}) + $signed({14'd0, c.len})
                   - $signed({14'd0, map_len[c.key]});
               if (b < 0) b = '0;
               if (b > $signed({3'b000, oktsl_pkg::BYTES_MAX}))
                  b = $signed({3'b000, oktsl_pkg::BYTES_MAX});
               bytes_sum = b[27:0];
               map_handle[c.key] = c.handle;
               map_len[c.key] = c.len;
               if (c.key > key_max) key_max = c.key;
            end else if (map_handle.num() >= CAP) r.status = oktsl_pkg::ST_FULL;
            else begin
               map_handle[c.key] = c.handle;
               map_len[c.key] = c.len;
               bytes_sum = bytes_sum + 28'(oktsl_pkg::HDR_BYTES) + 28'(c.len);
               if (bytes_sum > 28'(oktsl_pkg::BYTES_MAX))
                  bytes_sum = 28'(oktsl_pkg::BYTES_MAX);
               if (c.key > key_max) key_max = c.key;
            end
         end
         oktsl_pkg::OP_FIND: begin
            if (map_handle.exists(c.key)) begin
               r.hit = 1;
               r.key_out = c.key;
            end
         end
         oktsl_pkg::OP_START: begin
            cur_valid = (map_handle.first(k) == 1);
            cur_key = k;
         end
         default: begin
            if (cur_valid) begin
               r.hit = 1;
               r.key_out = cur_key;
               k = cur_key;
               cur_valid = (map_handle.next(k) == 1);
               cur_key = k;
            end
         end
      endcase
      if (r.hit) begin
         r.handle_out = map_handle[r.key_out];
         r.length_out = map_len[r.key_out];
      end
      r.entry_count = 11'(map_handle.num());
      r.byte_total = bytes_sum[26:0];
      r.largest_key = key_max;
      r.flush = (r.entry_count >= cfg_entry_lim) || (bytes_sum >= 28'(cfg_byte_lim));
      return r;
   endfunction

   // ---------------- driver ----------------
   int  gap_req = 0;
   bit  hold_send = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_table(pending_q.pop_front()));
            gap_req = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) gap_req = 0;
         end
         if (req_tvalid && !req_tready) begin
            // keep offering
         end else if (gap_req > 0) begin
            gap_req--;
            req_tvalid <= 0;
         end else if (pending_q.size() > 0 && !hold_send) begin
            req_tvalid <= 1;
            req_tdata <= {6'd0, pending_q[0].len, pending_q[0].handle,
                          pending_q[0].key, pending_q[0].op};
         end else req_tvalid <= 0;
      end
   end

   // ---------------- monitor ----------------
   int  gap_rsp = 0;
   int  hold_rsp = 0;
   int  idle_cycles = 0;
   always @(posedge clock) begin
      result_type act, exp_r;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            act = {rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[66:3], rsp_tdata[98:67],
                   rsp_tdata[114:99], rsp_tdata[125:115], rsp_tdata[152:126],
                   rsp_tdata[216:153], rsp_tdata[217]};
            if (expected_q.size() == 0) begin
               $display("%0t: result with nothing expected, actual %h", $time, act);
               errors++;
            end else begin
               exp_r = expected_q.pop_front();
               if (act.status !== exp_r.status || act.hit !== exp_r.hit ||
                   act.key_out !== exp_r.key_out || act.handle_out !== exp_r.handle_out ||
                   act.length_out !== exp_r.length_out ||
                   act.entry_count !== exp_r.entry_count ||
                   act.byte_total !== exp_r.byte_total ||
                   act.largest_key !== exp_r.largest_key || act.flush !== exp_r.flush) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp_r, act);
                  errors++;
               end
            end
            gap_rsp = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) gap_rsp = 0;
         end
         if (hold_rsp > 0) begin
            hold_rsp--;
            rsp_tready <= 0;
         end else if (gap_rsp > 0) begin
            gap_rsp--;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   logic [63:0] used_keys[$];

   task automatic push_item(logic [1:0] op, logic [63:0] k, logic [31:0] h, logic [15:0] l);
      item_type c;
      c.op = op; c.key = k; c.handle = h; c.len = l;
      pending_q.push_back(c);
      if (op == oktsl_pkg::OP_INSERT) used_keys.push_back(k);
   endtask

   function automatic logic [63:0] pick_key();
      if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   task automatic drain_all();
      wait (pending_q.size() == 0 && !req_tvalid);
      wait (expected_q.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [26:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         oktsl_pkg::REG_FROZEN:    cfg_frozen = val[0];
         oktsl_pkg::REG_ENTRY_LIM: cfg_entry_lim = val[10:0];
         oktsl_pkg::REG_BYTE_LIM:  cfg_byte_lim = val;
         oktsl_pkg::REG_NAME_LIM:  cfg_name_lim = val[15:0];
         default: ;
      endcase
   endtask

   task automatic random_phase(int n, int len_max);
      logic [1:0] op;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         op = r < 4 ? oktsl_pkg::OP_INSERT : r < 6 ? oktsl_pkg::OP_FIND :
              r < 7 ? oktsl_pkg::OP_START : oktsl_pkg::OP_NEXT;
         push_item(op, pick_key(), $urandom, 16'($urandom_range(0, len_max)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed part
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_START, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_FIND, 64'd5, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'd255);
      push_item(oktsl_pkg::OP_INSERT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_INSERT, 64'd100, 32'h1234_5678, 16'd256);
      push_item(oktsl_pkg::OP_INSERT, 64'd100, 32'h1234_5678, 16'd17);
      push_item(oktsl_pkg::OP_INSERT, 64'd100, 32'hAAAA_5555, 16'd3);
      push_item(oktsl_pkg::OP_FIND, 64'd100, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_FIND, 64'd101, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_START, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_INSERT, 64'd50, 32'd7, 16'd1);
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_INSERT, 64'd200, 32'd9, 16'd2);
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      push_item(oktsl_pkg::OP_NEXT, 64'd0, 32'd0, 16'd0);
      drain_all();
      // frozen table and odd limits
      write_reg(oktsl_pkg::REG_FROZEN, 27'd1);
      write_reg(oktsl_pkg::REG_ENTRY_LIM, 27'd1);
      write_reg(oktsl_pkg::REG_BYTE_LIM, 27'd1);
      push_item(oktsl_pkg::OP_INSERT, 64'd7, 32'd1, 16'd1);
      push_item(oktsl_pkg::OP_FIND, 64'd200, 32'd0, 16'd0);
      drain_all();
      write_reg(oktsl_pkg::REG_FROZEN, 27'd0);
      write_reg(oktsl_pkg::REG_ENTRY_LIM, 27'd0);
      write_reg(oktsl_pkg::REG_BYTE_LIM, 27'd0);
      write_reg(oktsl_pkg::REG_NAME_LIM, 27'd0);
      random_phase(60, 2);
      drain_all();
      // long receiver stall: block fills and stalls its input
      write_reg(oktsl_pkg::REG_NAME_LIM, 27'hFFFF);
      write_reg(oktsl_pkg::REG_ENTRY_LIM, 27'd1024);
      write_reg(oktsl_pkg::REG_BYTE_LIM, 27'h7FF_FFFF);
      hold_rsp = 400;
      random_phase(300, 65535);
      // sender pause until all results are in
      wait (pending_q.size() < 150);
      hold_send = 1;
      wait (expected_q.size() == 0 && !req_tvalid);
      repeat (20) @(posedge clock);
      hold_send = 0;
      drain_all();
      write_reg(oktsl_pkg::REG_ENTRY_LIM, 27'd700);
      write_reg(oktsl_pkg::REG_BYTE_LIM, 27'd2000000);
      random_phase(400, 65535);
      drain_all();
      // fill past capacity with fresh keys, then overwrites on a full table
      write_reg(oktsl_pkg::REG_BYTE_LIM, 27'd5000);
      for (int i = 0; i < 920; i++) push_item(oktsl_pkg::OP_INSERT, {$urandom, $urandom},
                                               $urandom, 16'($urandom));
      random_phase(140, 65535);
      drain_all();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
